>>> hw/rtl/radconv_pkg.sv
// Shared types, constants and character helpers for the radix converter.
// No dependencies; every other RTL file but the checker refers to this package by scoped names.
`default_nettype none

package radconv_pkg;

  localparam int IN_DIGITS  = 7;   // most input digits accepted per number
  localparam int OUT_DIGITS = 7;   // width of the output character field

  localparam int ACC_W    = 4 * IN_DIGITS;                        // holds 16**IN_DIGITS - 1
  localparam int SEEN_W   = $clog2(IN_DIGITS + 1);
  localparam int CNT_W    = $clog2(OUT_DIGITS + 1);
  localparam int POS_W    = (OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1;
  localparam int DSTEP_W  = (IN_DIGITS > 1) ? $clog2(IN_DIGITS) : 1;
  localparam int ERR_LEN  = 5;

  localparam logic [4:0] BASE_MIN   = 5'd2;
  localparam logic [4:0] BASE_MAX   = 5'd16;
  localparam logic [4:0] BASE_RESET = 5'd10;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_F     = 7'h46;
  localparam logic [6:0] CH_E     = 7'h45;
  localparam logic [6:0] CH_R     = 7'h52;
  localparam logic [6:0] CH_O     = 7'h4F;

  typedef enum logic [1:0] {
    ST_IN,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MD_NUM,
    MD_ZERO,
    MD_ERR
  } mode_t;

  typedef struct packed {
    logic       legal;
    logic [3:0] val;
  } dec_t;

  // Number as it stands once the current character is folded in.
  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             bad;
    logic [4:0]       dst_base;
  } fin_t;

  function automatic dec_t decode_char(input logic [6:0] c);
    dec_t d;
    d.legal = 1'b1;
    d.val   = 4'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d.val = 4'(c - CH_ZERO);
    end else if (c inside {[CH_A:CH_F]}) begin
      d.val = 4'(c - CH_A + 7'd10);
    end else begin
      d.legal = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [6:0] digit_ascii(input logic [3:0] d);
    logic [6:0] c;
    if (d > 4'd9) begin
      c = CH_A + 7'(d) - 7'd10;
    end else begin
      c = CH_ZERO + 7'(d);
    end
    return c;
  endfunction

  // Character of the right-justified "ERROR" text at field position pos.
  function automatic logic [6:0] err_char(input logic [POS_W-1:0] pos);
    int         t;
    logic [6:0] c;
    t = int'(pos) + ERR_LEN - OUT_DIGITS;
    case (t)
      0:       c = CH_E;
      1:       c = CH_R;
      2:       c = CH_R;
      3:       c = CH_O;
      4:       c = CH_R;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/radconv_acc.sv
// Input front end: digit decode, base sampling and value accumulation.
// Depends on radconv_pkg.
`default_nettype none

module radconv_acc (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [6:0]          digit_char,
  input  wire logic [4:0]          src_base,
  input  wire logic [4:0]          dst_base,
  input  wire logic                last_digit,
  output radconv_pkg::fin_t        fin
);

  logic [radconv_pkg::ACC_W-1:0]  acc;
  logic [radconv_pkg::SEEN_W-1:0] seen;
  logic                           bad;
  logic [4:0]                     held_src;
  logic [4:0]                     held_dst;

  logic                           first;
  logic [4:0]                     src_eff;
  logic [4:0]                     dst_eff;
  logic                           base_bad;
  logic                           legal;
  logic                           over;
  radconv_pkg::dec_t              dec;
  logic [radconv_pkg::ACC_W+4:0]  prod;
  logic [radconv_pkg::ACC_W-1:0]  acc_next;
  logic [radconv_pkg::SEEN_W-1:0] seen_next;
  logic                           bad_next;

  always_comb begin
    first    = (seen == '0);
    src_eff  = first ? src_base : held_src;
    dst_eff  = first ? dst_base : held_dst;
    base_bad = first && (src_base < radconv_pkg::BASE_MIN || src_base > radconv_pkg::BASE_MAX ||
                         dst_base < radconv_pkg::BASE_MIN || dst_base > radconv_pkg::BASE_MAX);
    dec      = radconv_pkg::decode_char(digit_char);
    legal    = dec.legal && ({1'b0, dec.val} < src_eff);
    over     = (seen >= radconv_pkg::SEEN_W'(radconv_pkg::IN_DIGITS));
    prod     = acc * src_eff;
    if (over || !legal) begin
      acc_next = acc;
    end else begin
      acc_next = prod[radconv_pkg::ACC_W-1:0] + radconv_pkg::ACC_W'(dec.val);
    end
    seen_next    = over ? seen : seen + 1'b1;
    bad_next     = bad | base_bad | over | !legal;
    fin.value    = acc_next;
    fin.bad      = bad_next;
    fin.dst_base = dst_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      seen     <= '0;
      bad      <= 1'b0;
      held_src <= radconv_pkg::BASE_RESET;
      held_dst <= radconv_pkg::BASE_RESET;
    end else if (accept) begin
      if (first) begin
        held_src <= src_base;
        held_dst <= dst_base;
      end
      // Drop the number once its last character is in.
      if (last_digit) begin
        acc  <= '0;
        seen <= '0;
        bad  <= 1'b0;
      end else begin
        acc  <= acc_next;
        seen <= seen_next;
        bad  <= bad_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/radconv_div.sv
// Shared divider: restoring division of the value by a small base, four bits per cycle.
// Depends on radconv_pkg.
`default_nettype none

module radconv_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [radconv_pkg::ACC_W-1:0] dividend,
  input  wire logic [4:0]                    divisor,
  output logic                               done,
  output logic [radconv_pkg::ACC_W-1:0]      quotient,
  output logic [3:0]                         remainder
);

  logic                            busy;
  logic [radconv_pkg::DSTEP_W-1:0] step;
  logic [radconv_pkg::ACC_W-1:0]   work;
  logic [4:0]                      rem;
  logic [4:0]                      div;
  logic [radconv_pkg::ACC_W-1:0]   work_next;
  logic [4:0]                      rem_next;

  // Four quotient bits per cycle; the remainder stays below the divisor.
  always_comb begin
    logic [4:0]                    r;
    logic [4:0]                    r2;
    logic [radconv_pkg::ACC_W-1:0] w;
    r = rem;
    w = work;
    for (int k = 0; k < 4; k++) begin
      r2 = {r[3:0], w[radconv_pkg::ACC_W-1]};
      w  = {w[radconv_pkg::ACC_W-2:0], 1'b0};
      if (r2 >= div) begin
        r    = r2 - div;
        w[0] = 1'b1;
      end else begin
        r = r2;
      end
    end
    work_next = w;
    rem_next  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == radconv_pkg::DSTEP_W'(radconv_pkg::IN_DIGITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      div  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem[3:0];

endmodule

`default_nettype wire

>>> hw/rtl/radix_converter_top.sv
// Radix converter top level: input front end, shared divider, digit store and output register.
// Depends on radconv_pkg, radconv_acc and radconv_div.
`default_nettype none

// A number arrives as ASCII digit items, most significant first, one item per
// cycle while in_stall is low; the source and target bases (2 to 16) are taken
// with the first item. The item flagged last_digit closes the number: the
// block then raises in_stall while it converts and emits exactly seven result
// items, the field right-justified and padded with spaces, a single '0' for
// zero, and right-justified "ERROR" for an illegal character, a base out of
// range, more than seven input digits or a result that needs more than seven
// digits. Conversion runs on one shared divider that retires four quotient bits
// a cycle; each output digit takes seven division steps and is then stored in
// the digit store, and no division runs for zero or bad input. Emission then
// follows, holding while out_stall is high. The last result item may still
// wait in the output register while the first item of the next number is
// taken.
module radix_converter_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [6:0] digit_char,
  input  wire logic [4:0] src_base,
  input  wire logic [4:0] dst_base,
  input  wire logic       last_digit,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_char,
  output logic            last_char
);

  radconv_pkg::state_t            state;
  radconv_pkg::state_t            state_next;
  radconv_pkg::mode_t             mode;
  logic [radconv_pkg::CNT_W-1:0]  count;
  logic [radconv_pkg::POS_W-1:0]  pos;
  logic [4:0]                     dst;
  logic [3:0]                     digits [radconv_pkg::OUT_DIGITS];

  radconv_pkg::fin_t              fin;
  logic                           accept;
  logic                           close_num;
  logic                           load;
  logic                           div_start;
  logic [radconv_pkg::ACC_W-1:0]  div_dividend;
  logic [4:0]                     div_divisor;
  logic                           div_done;
  logic [radconv_pkg::ACC_W-1:0]  quotient;
  logic [3:0]                     remainder;
  logic                           last_slot;
  logic                           last_pos;
  logic [6:0]                     ch;
  logic [radconv_pkg::CNT_W-1:0]  pad;

  assign accept    = in_valid && !in_stall;
  assign close_num = accept && last_digit;
  assign load      = !out_valid || !out_stall;
  assign last_slot = (count == radconv_pkg::CNT_W'(radconv_pkg::OUT_DIGITS - 1));
  assign last_pos  = (pos == radconv_pkg::POS_W'(radconv_pkg::OUT_DIGITS - 1));

  radconv_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .digit_char (digit_char),
    .src_base   (src_base),
    .dst_base   (dst_base),
    .last_digit (last_digit),
    .fin        (fin)
  );

  radconv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      radconv_pkg::ST_IN: begin
        if (close_num) begin
          if (fin.bad || fin.value == '0) begin
            state_next = radconv_pkg::ST_EMIT;
          end else begin
            state_next = radconv_pkg::ST_DIV;
          end
        end
      end
      radconv_pkg::ST_DIV: begin
        if (div_done && (quotient == '0 || last_slot)) begin
          state_next = radconv_pkg::ST_EMIT;
        end
      end
      radconv_pkg::ST_EMIT: begin
        if (load && last_pos) begin
          state_next = radconv_pkg::ST_IN;
        end
      end
      default: state_next = radconv_pkg::ST_IN;
    endcase
  end

  // Outputs of the sequencer: handshake and divider launch.
  always_comb begin
    in_stall     = 1'b1;
    div_start    = 1'b0;
    div_dividend = quotient;
    div_divisor  = dst;
    case (state)
      radconv_pkg::ST_IN: begin
        in_stall     = 1'b0;
        div_start    = close_num && !fin.bad && fin.value != '0;
        div_dividend = fin.value;
        div_divisor  = fin.dst_base;
      end
      radconv_pkg::ST_DIV: begin
        // Go again on the quotient while digits remain and the field has room.
        div_start = div_done && quotient != '0 && !last_slot;
      end
      radconv_pkg::ST_EMIT: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Character for the current field position; the digit store holds the
  // least significant digit at index zero.
  always_comb begin
    pad = radconv_pkg::CNT_W'(radconv_pkg::OUT_DIGITS) - count;
    ch  = radconv_pkg::CH_SPACE;
    case (mode)
      radconv_pkg::MD_ERR: begin
        ch = radconv_pkg::err_char(pos);
      end
      radconv_pkg::MD_ZERO: begin
        if (last_pos) begin
          ch = radconv_pkg::CH_ZERO;
        end
      end
      radconv_pkg::MD_NUM: begin
        if (radconv_pkg::CNT_W'(pos) >= pad) begin
          ch = radconv_pkg::digit_ascii(
                 digits[radconv_pkg::POS_W'(radconv_pkg::OUT_DIGITS - 1) - pos]);
        end
      end
      default: ch = radconv_pkg::CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= radconv_pkg::ST_IN;
      mode      <= radconv_pkg::MD_NUM;
      count     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == radconv_pkg::ST_IN && close_num) begin
        count <= '0;
        pos   <= '0;
        if (fin.bad) begin
          mode <= radconv_pkg::MD_ERR;
        end else if (fin.value == '0) begin
          mode <= radconv_pkg::MD_ZERO;
        end else begin
          mode <= radconv_pkg::MD_NUM;
        end
      end
      if (state == radconv_pkg::ST_DIV && div_done) begin
        count <= count + 1'b1;
        // Seventh digit stored and value still not exhausted: field too narrow.
        if (quotient != '0 && last_slot) begin
          mode <= radconv_pkg::MD_ERR;
        end
      end
      if (load) begin
        out_valid <= (state == radconv_pkg::ST_EMIT);
        if (state == radconv_pkg::ST_EMIT) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == radconv_pkg::ST_IN && close_num) begin
      dst <= fin.dst_base;
    end
    if (state == radconv_pkg::ST_DIV && div_done) begin
      digits[count[radconv_pkg::POS_W-1:0]] <= remainder;
    end
    if (load && state == radconv_pkg::ST_EMIT) begin
      out_char  <= ch;
      last_char <= last_pos;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/radconv_checker.sv
// Port-level checks for the radix converter, bound onto the top level.
// Depends on radix_converter_top's ports only.
`default_nettype none

module radconv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [6:0] digit_char,
  input wire logic [4:0] src_base,
  input wire logic [4:0] dst_base,
  input wire logic       last_digit,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [6:0] out_char,
  input wire logic       last_char
);

  // Hold a stalled result item.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_char))
    else $error("stalled result item changed");

  // Close of a number blocks further input while it converts.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_digit |=> in_stall)
    else $error("input taken right after the last digit");

  // Result items of one field follow back to back.
  a_field_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_char |=> out_valid)
    else $error("gap inside a result field");

  // Emit only space, digits or the letters of ERROR.
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char == 7'h20 || (out_char >= 7'h30 && out_char <= 7'h39) ||
                  (out_char >= 7'h41 && out_char <= 7'h46) ||
                  out_char == 7'h52 || out_char == 7'h4F)
    else $error("illegal result character");

endmodule

bind radix_converter_top radconv_checker u_radconv_checker (.*);

`default_nettype wire
